// ===== hdl/arpc_pkg.sv =====
// shared types, constants and saturation helpers of the attitude/rate pid controller
package arpc_pkg;

  localparam int DataW   = 32;
  localparam int GainW   = 31;
  localparam int StepW   = 20;
  localparam int CfgIdxW = 3;
  localparam int DvsW    = 20;
  localparam int DivW    = 54;
  localparam int DivCntW = $clog2(DivW + 1);
  localparam int ProdW   = 65;

  // reciprocal scaling of the integral increment by 1/1000000
  localparam int HalfW      = 26;
  localparam int MagW       = 2 * HalfW;
  localparam int RaccW      = 4 * HalfW;
  localparam int RecipShift = 71;
  localparam logic [MagW-1:0] RecipUs = 52'd2361183241434823;

  // reciprocal of 5 for the feedforward limit
  localparam int RecipFiveShift = 33;
  localparam logic signed [31:0] RecipFive = 32'sd1717986919;

  localparam logic [StepW-1:0]      MinStep  = 20'd100;
  localparam logic signed [31:0]    UsPerSS  = 32'sd1000000;
  localparam logic signed [31:0]    AlphaQ16 = 32'sd45875;
  localparam logic signed [31:0]    AlphaInv = 32'sd65536 - AlphaQ16;
  localparam logic signed [33:0]    Deg180   = 34'sd11796480;
  localparam logic signed [33:0]    Deg360   = 34'sd23592960;
  localparam logic signed [31:0]    Deg20    = 32'sd1310720;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOOP_MODE,
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_INT_LIM,
    CFG_DER_LIM,
    CFG_OUT_LIM,
    CFG_FF_GAIN
  } cfg_idx_e;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_ERR,
    CMD_MUL_P,
    CMD_P,
    CMD_MUL_I,
    CMD_GI,
    CMD_MUL_DT,
    CMD_INC_ABS,
    CMD_INC_PP0,
    CMD_INC_PP1,
    CMD_INC_PP2,
    CMD_INC_PP3,
    CMD_INT,
    CMD_SUM_A,
    CMD_MUL_DM,
    CMD_DIV_RATE,
    CMD_RATE,
    CMD_MUL_D,
    CMD_DRAW,
    CMD_MUL_A1,
    CMD_MUL_A2,
    CMD_FILT,
    CMD_MUL_DTG,
    CMD_MUL_F,
    CMD_FF,
    CMD_MUL_LIM,
    CMD_FFLIM,
    CMD_SUM_B,
    CMD_SUM_C,
    CMD_OUT
  } cmd_e;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_P,
    ST_MUL_I,
    ST_GI,
    ST_MUL_DT,
    ST_INC_ABS,
    ST_INC_PP0,
    ST_INC_PP1,
    ST_INC_PP2,
    ST_INC_PP3,
    ST_INT,
    ST_SUM_A,
    ST_MUL_DM,
    ST_DIV_DM,
    ST_WAIT_DM,
    ST_RATE_DM,
    ST_MUL_D,
    ST_DRAW,
    ST_MUL_A1,
    ST_MUL_A2,
    ST_FILT,
    ST_MUL_DTG,
    ST_DIV_DTG,
    ST_WAIT_DTG,
    ST_RATE_DTG,
    ST_MUL_F,
    ST_FF,
    ST_MUL_LIM,
    ST_FFLIM,
    ST_SUM_B,
    ST_SUM_C,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic loop_mode;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return signed'(v[31:0]);
  endfunction

  function automatic logic signed [31:0] limit31(input logic signed [65:0] v,
                                                 input logic [GainW-1:0] l);
    logic signed [65:0] lp;
    logic signed [65:0] ln;
    lp = signed'({35'd0, l});
    ln = -lp;
    if (v > lp) return signed'(lp[31:0]);
    else if (v < ln) return signed'(ln[31:0]);
    else return signed'(v[31:0]);
  endfunction

  // q16.16 product back to q16.16, floor, saturated
  function automatic logic signed [31:0] gain_sat(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = p >>> 16;
    return sat32(66'(s));
  endfunction

endpackage

// ===== hdl/arpc_if.sv =====
// request and result channel interfaces
interface arpc_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] target;
  logic signed [31:0] measured;
  logic [19:0]        step_us;
  modport source (output valid, target, measured, step_us, input ready);
  modport sink   (input valid, target, measured, step_us, output ready);
endinterface

interface arpc_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] drive;
  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

// ===== hdl/arpc_div.sv =====
// iterative signed-by-unsigned restoring divider, one quotient bit per cycle
module arpc_div
  import arpc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0]        divisor_i,
  output logic                   done_o,
  output logic signed [DivW:0]   quot_o
);

  logic [DvsW:0]    rem_q, rem_d;
  logic [DivW-1:0]  dvd_q, dvd_d;
  logic [DvsW-1:0]  dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DvsW:0]    rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[DvsW-1:0], dvd_q[DivW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      dvd_d = dividend_i[DivW-1] ? DivW'(-dividend_i) : DivW'(dividend_i);
      dvs_d = divisor_i;
      neg_d = dividend_i[DivW-1];
      cnt_d = DivCntW'(DivW);
    end else if (cnt_q != '0) begin
      rem_d = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      dvd_d = {dvd_q[DivW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -signed'({1'b0, dvd_q}) : signed'({1'b0, dvd_q});

endmodule

// ===== hdl/arpc_dp.sv =====
// datapath: config registers, loop state, shared multiplier and divider
module arpc_dp
  import arpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_e                 cmd_i,
  output dp_stat_t             stat_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [GainW-1:0]     cfg_wdata_i,
  input  logic signed [31:0]   target_i,
  input  logic signed [31:0]   measured_i,
  input  logic [StepW-1:0]     step_us_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   drive_o
);

  logic             mode_q;
  logic [GainW-1:0] gp_q, gi_q, gd_q, ilim_q, dlim_q, olim_q, ffg_q;

  logic signed [31:0] iacc_q, df_q, lm_q, lt_q;
  logic signed [31:0] tgt_q, meas_q, err_q, p_q, t_q, ff_q, sum_q, drive_q;
  logic [StepW-1:0]   dt_q;
  logic               win_q;
  logic               out_valid_q;
  logic signed [ProdW-1:0] prod_q, acc_q;
  logic [MagW-1:0]    rmag_q;
  logic               rneg_q;
  logic [RaccW-1:0]   racc_q;

  logic signed [32:0]     mul_a;
  logic signed [31:0]     mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic [MagW-1:0]        pp;
  logic signed [33:0]     err_raw, err_wrap;
  logic signed [31:0]     err_sat;
  logic [RaccW-RecipShift-1:0] inc_mag;
  logic signed [RaccW-RecipShift:0] inc_s;

  logic                   div_start;
  logic signed [DivW-1:0] div_dvd;
  logic [DvsW-1:0]        div_dvs;
  logic                   div_done;
  logic signed [DivW:0]   div_q;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i)
      CMD_MUL_P:   begin mul_a = signed'({2'b0, gp_q});  mul_b = err_q; end
      CMD_MUL_I:   begin mul_a = signed'({2'b0, gi_q});  mul_b = err_q; end
      CMD_MUL_DT:  begin mul_a = 33'(t_q); mul_b = signed'({12'd0, dt_q}); end
      CMD_INC_PP0: begin
        mul_a = signed'({7'd0, rmag_q[HalfW-1:0]});
        mul_b = signed'({6'd0, RecipUs[HalfW-1:0]});
      end
      CMD_INC_PP1: begin
        mul_a = signed'({7'd0, rmag_q[MagW-1:HalfW]});
        mul_b = signed'({6'd0, RecipUs[HalfW-1:0]});
      end
      CMD_INC_PP2: begin
        mul_a = signed'({7'd0, rmag_q[HalfW-1:0]});
        mul_b = signed'({6'd0, RecipUs[MagW-1:HalfW]});
      end
      CMD_INC_PP3: begin
        mul_a = signed'({7'd0, rmag_q[MagW-1:HalfW]});
        mul_b = signed'({6'd0, RecipUs[MagW-1:HalfW]});
      end
      CMD_MUL_DM:  begin mul_a = 33'(meas_q) - 33'(lm_q); mul_b = UsPerSS; end
      CMD_MUL_DTG: begin mul_a = 33'(tgt_q) - 33'(lt_q);  mul_b = UsPerSS; end
      CMD_MUL_D:   begin mul_a = signed'({2'b0, gd_q});  mul_b = t_q; end
      CMD_MUL_F:   begin mul_a = signed'({2'b0, ffg_q}); mul_b = t_q; end
      CMD_MUL_A1:  begin mul_a = 33'(df_q); mul_b = AlphaQ16; end
      CMD_MUL_A2:  begin mul_a = 33'(t_q);  mul_b = AlphaInv; end
      CMD_MUL_LIM: begin mul_a = signed'({2'b0, olim_q}); mul_b = RecipFive; end
      default:     ;
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign pp    = mul_p[MagW-1:0];

  // integral increment: magnitude times reciprocal, then sign back
  assign inc_mag = racc_q[RaccW-1:RecipShift];
  assign inc_s   = rneg_q ? -signed'({1'b0, inc_mag}) : signed'({1'b0, inc_mag});

  // error with angle wrap in angle mode, applied once
  always_comb begin
    err_raw  = 34'(tgt_q) - 34'(meas_q);
    err_wrap = err_raw;
    if (!mode_q) begin
      if (err_raw > Deg180) err_wrap = err_raw - Deg360;
      else if (err_raw < -Deg180) err_wrap = err_raw + Deg360;
    end
    err_sat = sat32(66'(err_wrap));
  end

  // divider only ever divides by the time step
  assign div_start = (cmd_i == CMD_DIV_RATE);
  assign div_dvd   = signed'(prod_q[DivW-1:0]);
  assign div_dvs   = dt_q;

  arpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // config and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      gp_q        <= '0;
      gi_q        <= '0;
      gd_q        <= '0;
      ilim_q      <= '0;
      dlim_q      <= '0;
      olim_q      <= '0;
      ffg_q       <= '0;
      iacc_q      <= '0;
      df_q        <= '0;
      lm_q        <= '0;
      lt_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_LOOP_MODE: mode_q <= cfg_wdata_i[0];
          CFG_GAIN_P:    gp_q   <= cfg_wdata_i;
          CFG_GAIN_I:    gi_q   <= cfg_wdata_i;
          CFG_GAIN_D:    gd_q   <= cfg_wdata_i;
          CFG_INT_LIM:   ilim_q <= cfg_wdata_i;
          CFG_DER_LIM:   dlim_q <= cfg_wdata_i;
          CFG_OUT_LIM:   olim_q <= cfg_wdata_i;
          CFG_FF_GAIN:   ffg_q  <= cfg_wdata_i;
          default:       ;
        endcase
      end
      if (cmd_i == CMD_OUT) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i)
        CMD_INT: if (mode_q || win_q) iacc_q <= limit31(66'(iacc_q) + 66'(inc_s), ilim_q);
        CMD_FILT: df_q <= limit31(66'(sat32(66'((66'(acc_q) + 66'(prod_q)) >>> 16))),
                                  dlim_q);
        CMD_OUT: begin
          lm_q <= meas_q;
          lt_q <= tgt_q;
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        tgt_q  <= target_i;
        meas_q <= measured_i;
        dt_q   <= (step_us_i < MinStep) ? MinStep : step_us_i;
      end
      CMD_ERR: begin
        err_q <= err_sat;
        win_q <= (err_sat < Deg20) && (err_sat > -Deg20);
      end
      CMD_MUL_P, CMD_MUL_I, CMD_MUL_DT, CMD_MUL_DM, CMD_MUL_DTG,
      CMD_MUL_D, CMD_MUL_F, CMD_MUL_A1, CMD_MUL_LIM: prod_q <= mul_p;
      CMD_MUL_A2: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      CMD_INC_ABS: begin
        rmag_q <= prod_q[ProdW-1] ? MagW'(-prod_q) : MagW'(prod_q);
        rneg_q <= prod_q[ProdW-1];
      end
      CMD_INC_PP0: racc_q <= RaccW'(pp);
      CMD_INC_PP1, CMD_INC_PP2: racc_q <= racc_q + {26'd0, pp, 26'd0};
      CMD_INC_PP3: racc_q <= racc_q + {pp, 52'd0};
      CMD_P:     p_q <= gain_sat(prod_q);
      CMD_GI:    t_q <= gain_sat(prod_q);
      CMD_RATE:  t_q <= sat32(66'(div_q));
      CMD_DRAW:  t_q <= sat32(-66'(gain_sat(prod_q)));
      CMD_FF:    ff_q <= gain_sat(prod_q);
      CMD_FFLIM: ff_q <= limit31(66'(ff_q),
                                 prod_q[RecipFiveShift+GainW-1:RecipFiveShift]);
      CMD_SUM_A: sum_q <= sat32(66'(p_q) + 66'(iacc_q));
      CMD_SUM_B: sum_q <= sat32(66'(sum_q) + 66'(df_q));
      CMD_SUM_C: sum_q <= sat32(66'(sum_q) + 66'(ff_q));
      CMD_OUT:   drive_q <= limit31(66'(sum_q), olim_q);
      default: ;
    endcase
  end

  assign stat_o.loop_mode = mode_q;
  assign stat_o.div_done  = div_done;
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign drive_o          = drive_q;

endmodule

// ===== hdl/arpc_ctrl.sv =====
// sequencer that walks the datapath through one control step
module arpc_ctrl
  import arpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output cmd_e     cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_ERR;
        end
      end
      ST_ERR:      begin cmd_o = CMD_ERR;     state_d = ST_MUL_P;   end
      ST_MUL_P:    begin cmd_o = CMD_MUL_P;   state_d = ST_P;       end
      ST_P:        begin cmd_o = CMD_P;       state_d = ST_MUL_I;   end
      ST_MUL_I:    begin cmd_o = CMD_MUL_I;   state_d = ST_GI;      end
      ST_GI:       begin cmd_o = CMD_GI;      state_d = ST_MUL_DT;  end
      ST_MUL_DT:   begin cmd_o = CMD_MUL_DT;  state_d = ST_INC_ABS; end
      ST_INC_ABS:  begin cmd_o = CMD_INC_ABS; state_d = ST_INC_PP0; end
      ST_INC_PP0:  begin cmd_o = CMD_INC_PP0; state_d = ST_INC_PP1; end
      ST_INC_PP1:  begin cmd_o = CMD_INC_PP1; state_d = ST_INC_PP2; end
      ST_INC_PP2:  begin cmd_o = CMD_INC_PP2; state_d = ST_INC_PP3; end
      ST_INC_PP3:  begin cmd_o = CMD_INC_PP3; state_d = ST_INT;     end
      ST_INT:      begin cmd_o = CMD_INT;     state_d = ST_SUM_A;   end
      ST_SUM_A: begin
        cmd_o   = CMD_SUM_A;
        state_d = stat_i.loop_mode ? ST_MUL_DM : ST_OUT;
      end
      ST_MUL_DM:   begin cmd_o = CMD_MUL_DM;   state_d = ST_DIV_DM;  end
      ST_DIV_DM:   begin cmd_o = CMD_DIV_RATE; state_d = ST_WAIT_DM; end
      ST_WAIT_DM:  if (stat_i.div_done) state_d = ST_RATE_DM;
      ST_RATE_DM:  begin cmd_o = CMD_RATE;     state_d = ST_MUL_D;   end
      ST_MUL_D:    begin cmd_o = CMD_MUL_D;    state_d = ST_DRAW;    end
      ST_DRAW:     begin cmd_o = CMD_DRAW;     state_d = ST_MUL_A1;  end
      ST_MUL_A1:   begin cmd_o = CMD_MUL_A1;   state_d = ST_MUL_A2;  end
      ST_MUL_A2:   begin cmd_o = CMD_MUL_A2;   state_d = ST_FILT;    end
      ST_FILT:     begin cmd_o = CMD_FILT;     state_d = ST_MUL_DTG; end
      ST_MUL_DTG:  begin cmd_o = CMD_MUL_DTG;  state_d = ST_DIV_DTG; end
      ST_DIV_DTG:  begin cmd_o = CMD_DIV_RATE; state_d = ST_WAIT_DTG; end
      ST_WAIT_DTG: if (stat_i.div_done) state_d = ST_RATE_DTG;
      ST_RATE_DTG: begin cmd_o = CMD_RATE;     state_d = ST_MUL_F;   end
      ST_MUL_F:    begin cmd_o = CMD_MUL_F;    state_d = ST_FF;      end
      ST_FF:       begin cmd_o = CMD_FF;       state_d = ST_MUL_LIM; end
      ST_MUL_LIM:  begin cmd_o = CMD_MUL_LIM;  state_d = ST_FFLIM;   end
      ST_FFLIM:    begin cmd_o = CMD_FFLIM;    state_d = ST_SUM_B;   end
      ST_SUM_B:    begin cmd_o = CMD_SUM_B;    state_d = ST_SUM_C;   end
      ST_SUM_C:    begin cmd_o = CMD_SUM_C;    state_d = ST_OUT;     end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o   = CMD_OUT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/attitude_rate_pid_controller_unit.sv =====
// top level of the attitude/rate pid controller
// One request carries a setpoint, a measurement (both signed q16.16) and a time
// step in microseconds (floored at 100); each request gives exactly one drive
// value on the result channel. The block handles one request at a time: ready
// is high only while the sequencer is idle. All multiplies go through one
// 33x32 multiplier; the two divisions by the time step go through one radix-2
// divider, and each holds the sequencer until the divider reports done. The
// scaling of the integral increment by 1/1000000 is a reciprocal multiply in
// four partial products and the feedforward limit (output limit / 5) is a
// single reciprocal multiply. The sequencer waits in its output state while
// the previous result still waits to be taken. Configuration is a plain write
// port (index as listed: mode, kp, ki, kd, integral limit, derivative limit,
// output limit, feedforward gain) and is meant to be written only while no
// request is in flight.
module attitude_rate_pid_controller_unit
  import arpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  arpc_in_if.sink            req_i,
  arpc_out_if.source         rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [GainW-1:0]   cfg_wdata_i
);

  cmd_e     cmd;
  dp_stat_t stat;
  logic     in_ready;

  // sequencer
  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic, loop state and result register
  arpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .target_i    (req_i.target),
    .measured_i  (req_i.measured),
    .step_us_i   (req_i.step_us),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .drive_o     (rsp_o.drive)
  );

  assign req_i.ready = in_ready;

endmodule

// ===== hdl/arpc_checker.sv =====
// port-level checks of the controller, bound to the top level
module arpc_checker
  import arpc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] drive,
  input logic               cfg_we,
  input logic [CfgIdxW-1:0] cfg_idx,
  input logic [GainW-1:0]   cfg_wdata
);

  logic [GainW-1:0] olim_q;
  logic [1:0]       pend_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      olim_q <= '0;
      pend_q <= '0;
    end else begin
      if (cfg_we && cfg_idx == CFG_OUT_LIM) olim_q <= cfg_wdata;
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(drive))
    else $error("result dropped or changed while stalled");

  a_drive_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (66'(drive) <= signed'({35'd0, olim_q})) &&
                  (66'(drive) >= -signed'({35'd0, olim_q})))
    else $error("drive beyond output limit");

  // one request in work plus at most one result waiting
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 2'd2)
    else $error("more than two requests in flight");

  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready)
    else $error("ready stayed high after a request");

endmodule

bind attitude_rate_pid_controller_unit arpc_checker u_arpc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (req_i.valid),
  .in_ready  (req_i.ready),
  .out_valid (rsp_o.valid),
  .out_ready (rsp_o.ready),
  .drive     (rsp_o.drive),
  .cfg_we    (cfg_we_i),
  .cfg_idx   (cfg_idx_i),
  .cfg_wdata (cfg_wdata_i)
);

// ===== verif/arpc_scoreboard.sv =====
// checker of the pid controller: shadow state, drive prediction and comparison
`timescale 1ns / 100ps
module arpc_scoreboard
  import arpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  arpc_in_if.sink            req_mon,
  arpc_out_if.sink           rsp_mon,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [GainW-1:0]   cfg_wdata_i,
  output int                 err_cnt_o,
  output int                 pending_o
);

  localparam longint Max32 = 64'sd2147483647;
  localparam longint Min32 = -64'sd2147483648;

  logic   mode_rate;
  longint kp, ki, kd, int_lim, der_lim, out_lim, kff;
  longint integ, dfilt, prev_meas, prev_tgt;
  logic signed [31:0] drive_q[$];

  function automatic longint clip32(longint v);
    if (v > Max32) return Max32;
    if (v < Min32) return Min32;
    return v;
  endfunction

  function automatic longint clamp_sym(longint v, longint l);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  // q16.16 product, floor, saturated; operands stay far below 64 bits
  function automatic longint scale_gain(longint g, longint v);
    return clip32((g * v) >>> 16);
  endfunction

  function automatic longint per_second(longint d, longint dt);
    return clip32((d * 1000000) / dt);
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt_o++;
  endtask

  function automatic logic signed [31:0] next_drive(longint tgt, longint meas, longint dt);
    longint e, p, inc, draw, ff, s;
    if (dt < 100) dt = 100;
    e = tgt - meas;
    if (!mode_rate) begin
      if (e > (64'sd180 <<< 16)) e -= (64'sd360 <<< 16);
      else if (e < -(64'sd180 <<< 16)) e += (64'sd360 <<< 16);
      e = clip32(e);
      p = scale_gain(kp, e);
      if (e < (64'sd20 <<< 16) && e > -(64'sd20 <<< 16)) begin
        inc = scale_gain(ki, e) * dt / 1000000;
        integ = clamp_sym(integ + inc, int_lim);
      end
      s = clip32(p + integ);
    end else begin
      e = clip32(e);
      p = scale_gain(kp, e);
      inc = scale_gain(ki, e) * dt / 1000000;
      integ = clamp_sym(integ + inc, int_lim);
      draw = clip32(-scale_gain(kd, per_second(meas - prev_meas, dt)));
      dfilt = (45875 * dfilt + (65536 - 45875) * draw) >>> 16;
      dfilt = clamp_sym(clip32(dfilt), der_lim);
      ff = clamp_sym(scale_gain(kff, per_second(tgt - prev_tgt, dt)), out_lim / 5);
      s = clip32(clip32(clip32(p + integ) + dfilt) + ff);
    end
    prev_meas = meas;
    prev_tgt = tgt;
    return 32'(clamp_sym(s, out_lim));
  endfunction

  assign pending_o = drive_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_rate <= 1'b0;
      {kp, ki, kd, int_lim, der_lim, out_lim, kff} <= '0;
      {integ, dfilt, prev_meas, prev_tgt} <= '0;
      err_cnt_o <= 0;
      drive_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_LOOP_MODE: mode_rate = cfg_wdata_i[0];
          CFG_GAIN_P:    kp = cfg_wdata_i;
          CFG_GAIN_I:    ki = cfg_wdata_i;
          CFG_GAIN_D:    kd = cfg_wdata_i;
          CFG_INT_LIM:   int_lim = cfg_wdata_i;
          CFG_DER_LIM:   der_lim = cfg_wdata_i;
          CFG_OUT_LIM:   out_lim = cfg_wdata_i;
          CFG_FF_GAIN:   kff = cfg_wdata_i;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        drive_q.push_back(next_drive(longint'(req_mon.target), longint'(req_mon.measured),
                                     longint'(req_mon.step_us)));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (drive_q.size() == 0) begin
          report("unexpected drive", rsp_mon.drive, 'x);
        end else if (rsp_mon.drive !== drive_q[0]) begin
          report("drive", rsp_mon.drive, drive_q.pop_front());
        end else begin
          void'(drive_q.pop_front());
        end
      end
    end
  end

endmodule

// ===== verif/attitude_rate_pid_controller_unit_tb.sv =====
// stimulus and verdict for the attitude/rate pid controller
`timescale 1ns / 100ps
module attitude_rate_pid_controller_unit_tb;
  import arpc_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [GainW-1:0] cfg_wdata_i = '0;
  int err_cnt, pending;
  int idle_cycles = 0;
  int stall_mode = 0;

  arpc_in_if  req_ch ();
  arpc_out_if rsp_ch ();

  initial begin
    req_ch.valid = 1'b0;
    req_ch.target = '0;
    req_ch.measured = '0;
    req_ch.step_us = '0;
    rsp_ch.ready = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  attitude_rate_pid_controller_unit dut (
    .clk_i, .rst_ni, .req_i(req_ch.sink), .rsp_o(rsp_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  arpc_scoreboard u_check (
    .clk_i, .rst_ni, .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .err_cnt_o(err_cnt), .pending_o(pending)
  );

  // receiver stall pattern: phases of always-ready, random and mostly stalled
  always @(posedge clk_i) begin
    if ($urandom_range(0, 499) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= $urandom_range(0, 1);
      default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // watchdog: nothing accepted on either side for too long
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [GainW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // let all drives drain, then the block's own tail, before touching config
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_gains(logic mode, logic [GainW-1:0] p, logic [GainW-1:0] i,
                           logic [GainW-1:0] d, logic [GainW-1:0] il,
                           logic [GainW-1:0] dl, logic [GainW-1:0] ol,
                           logic [GainW-1:0] ff);
    write_reg(CFG_LOOP_MODE, GainW'(mode));
    write_reg(CFG_GAIN_P, p);
    write_reg(CFG_GAIN_I, i);
    write_reg(CFG_GAIN_D, d);
    write_reg(CFG_INT_LIM, il);
    write_reg(CFG_DER_LIM, dl);
    write_reg(CFG_OUT_LIM, ol);
    write_reg(CFG_FF_GAIN, ff);
  endtask

  // one request, held until taken
  task automatic send(logic signed [31:0] tgt, logic signed [31:0] meas, logic [19:0] dt);
    req_ch.valid <= 1'b1;
    req_ch.target <= tgt;
    req_ch.measured <= meas;
    req_ch.step_us <= dt;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic pause();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [GainW-1:0] rnd_gain();
    case ($urandom_range(0, 3))
      0: return GainW'($urandom_range(0, 32'h0002_0000));
      1: return GainW'($urandom_range(0, 32'h0040_0000));
      2: return GainW'($urandom);
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      2: return 32'($signed($urandom_range(0, 32'h0050_0000)) - 32'sh0028_0000);
      3: return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000);
    endcase
  endfunction

  function automatic logic [19:0] rnd_step();
    case ($urandom_range(0, 5))
      0: return 20'($urandom_range(0, 99));
      1: return 20'hFFFFF;
      2: return 20'($urandom);
      default: return 20'($urandom_range(100, 5000));
    endcase
  endfunction

  initial begin
    int burst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero limits after reset: every drive clamps to zero
    send(32'sh0001_0000, 32'sh0, 20'd0);
    pause();
    drain();

    // angle loop: wrap, integral gating, step extremes
    set_gains(1'b0, 31'h0002_0000, 31'h0010_0000, '0, 31'h0100_0000, '0,
              31'h7FFF_FFFF, '0);
    send(32'sh00C8_0000, 32'sh0, 20'd1000);        // wrap down across 180
    send(-32'sh00C8_0000, 32'sh0, 20'd50);         // wrap up, short step
    send(32'sh0013_0000, 32'sh0, 20'd1000);        // just inside the gate
    send(32'sh0014_0000, 32'sh0, 20'd1000);        // gate closed at 20
    send(32'sh7FFF_FFFF, 32'sh8000_0000, 20'hFFFFF); // step beyond range
    send(32'sh8000_0000, 32'sh7FFF_FFFF, 20'd100);
    send(32'sh0, 32'sh0, 20'd0);
    pause();
    drain();

    // rate loop with every term active
    set_gains(1'b1, 31'h0001_8000, 31'h0004_0000, 31'h0000_4000, 31'h0200_0000,
              31'h0100_0000, 31'h0400_0000, 31'h0000_2000);
    send(32'sh0010_0000, 32'sh0, 20'd1000);
    send(32'sh0010_0000, 32'sh0008_0000, 20'd10);
    send(-32'sh0010_0000, 32'sh7FFF_FFFF, 20'd100);
    send(32'sh7FFF_FFFF, 32'sh8000_0000, 20'hFFFFF);
    send(32'sh8000_0000, 32'sh7FFF_FFFF, 20'd0);
    send(32'sh0, 32'sh0, 20'd2500);
    pause();
    drain();

    // rate loop with maximum gains and limits
    set_gains(1'b1, '1, '1, '1, '1, '1, '1, '1);
    send(32'sh7FFF_FFFF, 32'sh8000_0000, 20'd100);
    send(32'sh8000_0000, 32'sh7FFF_FFFF, 20'd100);
    send(32'sh0000_0001, 32'sh0, 20'hFFFFF);
    pause();
    drain();

    // random phases, each with fresh gains
    for (int ph = 0; ph < 12; ph++) begin
      set_gains(ph[0], rnd_gain(), rnd_gain(), rnd_gain(), rnd_gain(), rnd_gain(),
                rnd_gain(), rnd_gain());
      for (int n = 0; n < 50; n += burst) begin
        burst = $urandom_range(1, 8);
        for (int k = 0; k < burst; k++) send(rnd_val(), rnd_val(), rnd_step());
        if ($urandom_range(0, 2) != 0) begin
          req_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk_i);
        end
      end
      pause();
      drain();
    end

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
